[rtl/tick_task_scheduler_table_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tick task scheduler table
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_TABLE_CORE_MACROS_SVH
`define TICK_TASK_SCHEDULER_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types and codes shared by the tick task scheduler table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam logic [1:0] MODE_ADD      = 2'd0;
	localparam logic [1:0] MODE_DELETE   = 2'd1;
	localparam logic [1:0] MODE_TICK     = 2'd2;
	localparam logic [1:0] MODE_DISPATCH = 2'd3;

	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_NONE       = 2'd3;

	localparam int MAX_RESULTS = 8;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  run_count;
	} slot_word_t;

	localparam int SLOT_WORD_W = $bits(slot_word_t);

	typedef struct packed {
		logic load;
		logic add;
		logic scan;
		logic fin;
	} tts_cmd_t;

	typedef struct packed {
		logic add_done;
		logic scan_done;
		logic out_free;
	} tts_sts_t;

endpackage

`default_nettype wire

[rtl/tts_ram.sv]
// ----------------------------------------------------------------------------
// tts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/tts_ctrl.sv]
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: accepts one beat, runs the add search or the table scan (delete
// needs neither), then hands the final result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	output tts_pkg::tts_cmd_t cmd,
	input  tts_pkg::tts_sts_t sts
);
	import tts_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADD  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (mode)
						MODE_ADD:    state_d = S_ADD;
						MODE_DELETE: state_d = S_FIN;
						default:     state_d = S_SCAN;
					endcase
				end
			end
			S_ADD: begin
				if (sts.add_done) state_d = S_FIN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && in_valid;
	assign cmd.add  = (state_q == S_ADD);
	assign cmd.scan = (state_q == S_SCAN);
	assign cmd.fin  = (state_q == S_FIN);

endmodule

`default_nettype wire

[rtl/tts_datapath.sv]
// ----------------------------------------------------------------------------
// tts_datapath
// Slot table (valid flags plus slot RAM), scan pointer, evaluate stage,
// held dispatch result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_task_scheduler_table_core_macros.svh"

module tts_datapath #(
	parameter int TASKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tts_pkg::tts_cmd_t cmd,
	output tts_pkg::tts_sts_t sts,
	input  logic [1:0]        mode,
	input  logic [2:0]        target_slot,
	input  logic [7:0]        task_tag,
	input  logic [15:0]       start_delay,
	input  logic [15:0]       repeat_period,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        slot,
	output logic [7:0]        dispatched_tag,
	output logic [1:0]        status,
	output logic              last
);
	import tts_pkg::*;

	localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int PW = $clog2(TASKS + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	logic [1:0]       mode_q;
	logic [7:0]       tag_q;
	logic [15:0]      dly_q;
	logic [15:0]      per_q;

	logic [TASKS-1:0] valid_q;
	logic [TASKS-1:0] valid_d;
	logic [PW-1:0]    ptr_q;
	logic [NW-1:0]    n_q;
	logic             ev_valid_s1;
	logic [IW-1:0]    ev_idx_s1;

	logic [2:0]       res_slot_q;
	logic [7:0]       res_tag_q;
	logic [1:0]       res_status_q;
	logic             res_held_q;

	logic             out_valid_q;
	logic [2:0]       out_slot_q;
	logic [7:0]       out_tag_q;
	logic [1:0]       out_status_q;
	logic             out_last_q;

	logic [IW-1:0]          aidx;
	logic                   slot_free;
	logic                   add_last;
	logic [SLOT_WORD_W-1:0] ram_rdata;
	slot_word_t             ev_word;
	slot_word_t             tick_word;
	slot_word_t             disp_word;
	logic                   is_disp;
	logic                   out_free;
	logic                   ev_live;
	logic                   pending;
	logic                   ev_stall;
	logic                   ev_take;
	logic                   issue;
	logic                   push;
	logic                   fin_load;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	slot_word_t             ram_wdata;

	assign aidx      = ptr_q[IW-1:0];
	assign slot_free = !valid_q[aidx];
	assign add_last  = (aidx == IW'(TASKS - 1));
	assign ev_word   = valid_q[ev_idx_s1] ? slot_word_t'(ram_rdata) : '0;
	assign is_disp   = (mode_q == MODE_DISPATCH);
	assign out_free  = !out_valid_q || !out_stall;
	assign ev_live   = cmd.scan && ev_valid_s1 && (n_q < NW'(MAX_RESULTS));
	assign pending   = ev_live && is_disp && (ev_word.run_count != 8'd0);
	assign ev_stall  = pending && res_held_q && !out_free;
	assign ev_take   = pending && !ev_stall;
	assign issue     = cmd.scan && !ev_stall && (ptr_q < PW'(TASKS))
		&& (n_q < NW'(MAX_RESULTS));
	assign push      = ev_take && res_held_q;
	assign fin_load  = cmd.fin && out_free;

	always_comb begin
		tick_word = ev_word;
		if (ev_word.delay == 16'd0) begin
			if (ev_word.run_count != 8'hFF) tick_word.run_count = ev_word.run_count + 8'd1;
			if (ev_word.period != 16'd0) tick_word.delay = ev_word.period;
		end else begin
			tick_word.delay = ev_word.delay - 16'd1;
		end
		disp_word = ev_word;
		disp_word.run_count = ev_word.run_count - 8'd1;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ev_idx_s1;
		ram_wdata = tick_word;
		priority if (cmd.add) begin
			ram_we    = slot_free;
			ram_waddr = aidx;
			ram_wdata = '{tag: tag_q, delay: dly_q, period: per_q, run_count: 8'd0};
		end else if (ev_live && !is_disp) begin
			ram_we    = valid_q[ev_idx_s1];
		end else if (ev_take) begin
			ram_we    = 1'b1;
			ram_wdata = disp_word;
		end
	end

	always_comb begin
		valid_d = valid_q;
		if (cmd.load && (mode == MODE_DELETE)) begin
			for (int i = 0; i < TASKS; i++) begin
				if (int'(target_slot) == i) valid_d[i] = 1'b0;
			end
		end
		if (cmd.add && slot_free) valid_d[aidx] = 1'b1;
		if (ev_take && (ev_word.period == 16'd0)) valid_d[ev_idx_s1] = 1'b0;
	end

	tts_ram #(
		.WIDTH(SLOT_WORD_W),
		.DEPTH(TASKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(aidx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ptr_q       <= '0;
			n_q         <= '0;
			ev_valid_s1 <= 1'b0;
			res_held_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if ((cmd.add && !slot_free && !add_last) || issue) begin
				ptr_q <= ptr_q + PW'(1);
			end
			if (cmd.load) begin
				n_q <= '0;
			end else if (ev_take) begin
				n_q <= n_q + NW'(1);
			end
			if (cmd.load) begin
				ev_valid_s1 <= 1'b0;
			end else if (!ev_stall) begin
				ev_valid_s1 <= issue;
			end
			if (cmd.load) begin
				res_held_q <= 1'b0;
			end else if (ev_take) begin
				res_held_q <= 1'b1;
			end
			if (push || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q       <= mode;
			tag_q        <= task_tag;
			dly_q        <= start_delay;
			per_q        <= repeat_period;
			res_slot_q   <= (mode == MODE_DELETE) ? target_slot : 3'd0;
			res_tag_q    <= 8'd0;
			res_status_q <= (mode == MODE_DISPATCH) ? ST_NONE : ST_DONE;
		end else if (cmd.add) begin
			res_slot_q   <= slot_free ? 3'(ptr_q) : 3'd0;
			res_status_q <= slot_free ? ST_DONE : ST_FULL;
		end else if (ev_take) begin
			res_slot_q   <= 3'(ev_idx_s1);
			res_tag_q    <= ev_word.tag;
			res_status_q <= ST_DISPATCHED;
		end
		if (!ev_stall) begin
			ev_idx_s1 <= aidx;
		end
		if (push || fin_load) begin
			out_slot_q   <= res_slot_q;
			out_tag_q    <= res_tag_q;
			out_status_q <= res_status_q;
			out_last_q   <= fin_load;
		end
	end

	assign sts.add_done  = cmd.add && (slot_free || add_last);
	assign sts.scan_done = cmd.scan && !ev_valid_s1
		&& ((ptr_q == PW'(TASKS)) || (n_q == NW'(MAX_RESULTS)));
	assign sts.out_free  = out_free;

	assign out_valid      = out_valid_q;
	assign slot           = out_slot_q;
	assign dispatched_tag = out_tag_q;
	assign status         = out_status_q;
	assign last           = out_last_q;

	`TTS_ASSERT_NXT(a_ev_hold, ev_stall, ev_valid_s1 && $stable(ev_idx_s1), "ev stage lost on stall")
	`TTS_ASSERT_IMP(a_n_bound, 1'b1, n_q <= NW'(MAX_RESULTS), "dispatch count past limit")
	`TTS_ASSERT_NXT(a_fin_last, fin_load, out_valid_q && out_last_q, "final beat not marked last")
	`TTS_ASSERT_IMP(a_we_src, ram_we, cmd.add || cmd.scan, "slot write outside add or scan")

endmodule

`default_nettype wire

[rtl/tick_task_scheduler_table_core.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler_table_core
// Time-triggered cooperative task table with add, delete, tick and dispatch.
// ----------------------------------------------------------------------------
// One command beat at a time. Add checks one slot per cycle for the lowest
// free one, then hands over the result. Tick streams every slot through the
// slot RAM read port, one slot per cycle; dispatch streams slots the same way
// until eight have been dispatched, one slot per cycle unless the output is
// stalled while a dispatched beat waits, and every command holds its hand-over
// while the output register is full and stalled. Dispatch gives one beat per
// pending slot, in slot order, at most eight, the last one marked by last, or
// a single beat with status none if no slot is pending. Valid flags clear at
// reset, so the table is usable at once.
`default_nettype none

module tick_task_scheduler_table_core #(
	parameter int TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  target_slot,
	input  logic [7:0]  task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  slot,
	output logic [7:0]  dispatched_tag,
	output logic [1:0]  status,
	output logic        last
);
	import tts_pkg::*;

	tts_cmd_t cmd;
	tts_sts_t sts;

	tts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode    (mode),
		.cmd     (cmd),
		.sts     (sts)
	);

	tts_datapath #(
		.TASKS(TASKS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.target_slot   (target_slot),
		.task_tag      (task_tag),
		.start_delay   (start_delay),
		.repeat_period (repeat_period),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.slot          (slot),
		.dispatched_tag(dispatched_tag),
		.status        (status),
		.last          (last)
	);

endmodule

`default_nettype wire
